// ===== rtl/core/sap_pkg.sv =====
// shared widths and register codes of the allpass delay filter
package sap_pkg;

  // fixed widths of the configuration registers
  localparam int unsigned DLY_W     = 13;
  localparam int unsigned GAIN_W    = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  // q1.15 coefficient: fraction bits and the round-half-up offset
  localparam int unsigned FRAC_W     = 15;
  localparam int unsigned ROUND_HALF = 16384;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 2'd1;

  // register reset values
  localparam logic [DLY_W-1:0]  DELAY_RST = 13'd1;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 16'd0;

endpackage

// ===== rtl/core/sap_gain_mul.sv =====
// shared gain multiplier with registered product and round-half-up output
module sap_gain_mul
  import sap_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [GAIN_W-1:0]       gain_i,
  input  logic signed [SAMPLE_WIDTH-1:0] smp_i,
  output logic signed [SAMPLE_WIDTH:0]   res_o
);

  localparam int unsigned PROD_W = GAIN_W + SAMPLE_WIDTH;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd_sum;

  // product register, loaded on each use of the unit
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(gain_i) * PROD_W'(smp_i);
    end
  end

  // add half an lsb, then floor by dropping the fraction bits
  assign rnd_sum = prod_q + $signed(PROD_W'(ROUND_HALF));
  assign res_o   = $signed(rnd_sum[PROD_W-1:FRAC_W]);

endmodule

// ===== rtl/core/sap_delay_line.sv =====
// circular delay memory with write pointer, read address and fill tracking
module sap_delay_line
  import sap_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 8192,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [DLY_W-1:0]        delay_i,
  input  logic                    wr_en_i,
  input  logic [SAMPLE_WIDTH-1:0] wr_data_i,
  output logic [SAMPLE_WIDTH-1:0] rd_data_o
);

  localparam int unsigned AW = $clog2(BUFFER_DEPTH);
  localparam int unsigned CW = ((AW > DLY_W) ? AW : DLY_W) + 1;

  logic [SAMPLE_WIDTH-1:0] mem_q [BUFFER_DEPTH];
  logic [SAMPLE_WIDTH-1:0] rd_q;
  logic [AW-1:0]           wp_q, wp_d;
  logic                    wrapped_q, wrapped_d;
  logic                    rd_ok_q;
  logic [CW-1:0]           d_raw, d_eff, wp_ext, rp_ext;
  logic [AW-1:0]           rp;

  // effective delay: zero reads as one, clamp below the depth
  assign d_raw = CW'(delay_i);
  always_comb begin
    priority if (d_raw == '0) begin
      d_eff = CW'(1);
    end else if (d_raw > CW'(BUFFER_DEPTH - 1)) begin
      d_eff = CW'(BUFFER_DEPTH - 1);
    end else begin
      d_eff = d_raw;
    end
  end

  // read address behind the write pointer, wrapping at the depth
  assign wp_ext = CW'(wp_q);
  always_comb begin
    if (wp_ext >= d_eff) begin
      rp_ext = wp_ext - d_eff;
    end else begin
      rp_ext = wp_ext + CW'(BUFFER_DEPTH) - d_eff;
    end
  end
  assign rp = rp_ext[AW-1:0];

  // pointer advance and first-wrap flag
  always_comb begin
    wp_d      = wp_q;
    wrapped_d = wrapped_q;
    if (wr_en_i) begin
      if (wp_q == AW'(BUFFER_DEPTH - 1)) begin
        wp_d      = '0;
        wrapped_d = 1'b1;
      end else begin
        wp_d = wp_q + AW'(1);
      end
    end
  end

  // control state; an entry counts as written once the pointer passed it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
      rd_ok_q   <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      wrapped_q <= wrapped_d;
      rd_ok_q   <= wrapped_q || (wp_ext >= d_eff);
    end
  end

  // delay memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wp_q] <= wr_data_i;
    end
    rd_q <= mem_q[rp];
  end

  // never-written entries read as the cleared value
  assign rd_data_o = rd_ok_q ? rd_q : '0;

endmodule

// ===== rtl/core/schroeder_allpass_delay_filter.sv =====
// schroeder allpass filter over a circular delay memory, top level
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: in_sample
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: out_sample
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
// each sample is handled in steps: accept, two passes through the single shared
// gain multiplier with a subtract in between, and a final add into the output
// register; the registered read of the delay memory overlaps the first step.
// no clearing pass after reset: a fill flag makes unwritten entries read zero.
// the output register lets the next sample be accepted while a result waits;
// a stalled output holds the block in its last step until the result is taken.
module schroeder_allpass_delay_filter
  import sap_pkg::*;
#(
  parameter int unsigned BUFFER_DEPTH = 8192,
  parameter int unsigned SAMPLE_WIDTH = 24,
  localparam int unsigned TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  // sample input
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TDATA_W-1:0]   s_axis_tdata,   // in_sample
  // sample output
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [TDATA_W-1:0]   m_axis_tdata    // out_sample
);

  localparam int unsigned SW = SAMPLE_WIDTH;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_VSUB = 5'b00100,
    ST_MUL2 = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [DLY_W-1:0]       delay_q;
  logic signed [GAIN_W-1:0] gain_q;
  logic signed [SW-1:0]   x_q, v_q, dly_q, y_q;
  logic signed [SW-1:0]   v_sat, y_sat;
  logic signed [SW+1:0]   v_diff, y_sum;
  logic                   out_vld_q;
  logic                   in_req, out_free;
  logic [SW-1:0]          rd_data;
  logic signed [SW-1:0]   mul_opd;
  logic signed [SW:0]     mul_res;
  logic                   mul_en, mem_we;

  assign in_req   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_vld_q || m_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DELAY_RST;
      gain_q  <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DELAY: delay_q <= cfg_data_i[DLY_W-1:0];
        CFG_GAIN:  gain_q  <= $signed(cfg_data_i[GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // delay memory
  sap_delay_line #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .SAMPLE_WIDTH (SW)
  ) u_line (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .delay_i   (delay_q),
    .wr_en_i   (mem_we),
    .wr_data_i (v_sat),
    .rd_data_o (rd_data)
  );

  // shared multiplier: delayed sample first, then the new v
  assign mul_opd = (state_q == ST_MUL2) ? v_q : $signed(rd_data);
  assign mul_en  = (state_q == ST_MUL1) || (state_q == ST_MUL2);
  assign mem_we  = (state_q == ST_VSUB);

  sap_gain_mul #(
    .SAMPLE_WIDTH (SW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .gain_i (gain_q),
    .smp_i  (mul_opd),
    .res_o  (mul_res)
  );

  // v = sat(x - g*delayed)
  assign v_diff = {{2{x_q[SW-1]}}, x_q} - {mul_res[SW], mul_res};
  always_comb begin
    if (v_diff[SW+1:SW-1] == '0 || v_diff[SW+1:SW-1] == '1) begin
      v_sat = v_diff[SW-1:0];
    end else begin
      v_sat = v_diff[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

  // y = sat(g*v + delayed)
  assign y_sum = {mul_res[SW], mul_res} + {{2{dly_q[SW-1]}}, dly_q};
  always_comb begin
    if (y_sum[SW+1:SW-1] == '0 || y_sum[SW+1:SW-1] == '1) begin
      y_sat = y_sum[SW-1:0];
    end else begin
      y_sat = y_sum[SW+1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_req) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_VSUB;
      ST_VSUB: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      x_q <= $signed(s_axis_tdata[SW-1:0]);
    end
    if (state_q == ST_MUL1) begin
      dly_q <= $signed(rd_data);
    end
    if (state_q == ST_VSUB) begin
      v_q <= v_sat;
    end
    if (state_q == ST_OUT && out_free) begin
      y_q <= y_sat;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = TDATA_W'($unsigned(y_q));

`ifndef SYNTH
  // an accepted request always starts the first multiply
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> state_q == ST_MUL1)
    else $error("accepted request did not start the sequence");

  // a new result only appears out of the final step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
    else $error("output valid rose outside the final step");

  // a blocked final step keeps waiting and keeps the input closed
  a_out_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_free) |=> (state_q == ST_OUT && !s_axis_tready))
    else $error("final step left while the output was blocked");
`endif

endmodule
